// ===== rtl/ncr_pkg.sv =====
// shared types and constants for the numeric character reference decoder
// no dependencies
`timescale 1ns / 1ps

package ncr_pkg;

    localparam int CHAR_W          = 32;
    localparam int CODE_WIDTH_DEF  = 32;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_X_LC  = 8'h78;
    localparam logic [7:0] CH_X_UC  = 8'h58;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    typedef enum logic [1:0] {
        KIND_LITERAL = 2'd0,
        KIND_ENTITY  = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    // one queue entry; pair means an '&' beat goes out ahead of code
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        t_kind             kind;
        logic              pair;
    } t_rec;

endpackage

// ===== rtl/numeric_char_ref_decoder.sv =====
// top level of the numeric character reference decoder: front end, queue, back end
// depends on ncr_pkg, ncr_front, ncr_fifo, ncr_back
//
//   channel   handshake      beat
//   input     push / full    i_in_byte, i_end_of_string
//   result    empty / pop    o_char_code, o_kind, o_last
//
// one text byte per cycle while full is low; each byte is parsed in the cycle it is taken
// a beat is loaded from the queue head into the output register once that register is empty or being popped
// an '&' not followed by '#' gives two beats: the '&' and then the byte after it
// full rises only when the queue of QUEUE_DEPTH entries is full
// synchronous active-low reset empties queue and output and returns to plain text
`timescale 1ns / 1ps

module numeric_char_ref_decoder #(
    parameter int CODE_WIDTH  = ncr_pkg::CODE_WIDTH_DEF,
    parameter int QUEUE_DEPTH = ncr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_string,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_char_code,
    output logic [1:0]  o_kind,
    output logic        o_last
);
    import ncr_pkg::*;

    logic  w_accept;
    logic  w_wr;
    t_rec  w_wr_rec;
    logic  w_q_full;
    logic  w_q_empty;
    logic  w_q_rd;
    t_rec  w_q_data;
    t_kind w_kind;

    assign w_accept = push && !w_q_full;
    assign full     = w_q_full;

    ncr_front #(
        .CODE_WIDTH (CODE_WIDTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_in_byte       (i_in_byte),
        .i_end_of_string (i_end_of_string),
        .o_wr            (w_wr),
        .o_rec           (w_wr_rec)
    );

    ncr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_data  (w_wr_rec),
        .o_full  (w_q_full),
        .i_rd    (w_q_rd),
        .o_empty (w_q_empty),
        .o_data  (w_q_data)
    );

    ncr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_q_empty),
        .i_q_data    (w_q_data),
        .o_q_rd      (w_q_rd),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_char_code (o_char_code),
        .o_kind      (w_kind),
        .o_last      (o_last)
    );

    assign o_kind = w_kind;

    a_queue_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_full && w_q_empty))
        else $error("queue full and empty together");

    a_first_of_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_last) |-> (o_kind == KIND_LITERAL && o_char_code == 32'(CH_AMP)))
        else $error("non-last beat is not a literal ampersand");

    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_last) |=> (!empty && o_last))
        else $error("second beat of pair missing");

    a_error_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_ERROR) |-> (o_char_code == '0 && o_last))
        else $error("error beat carries a code");

endmodule

// ===== rtl/ncr_front.sv =====
// front end: accepts text bytes, runs the reference parser, emits queue entries
// depends on ncr_pkg
`timescale 1ns / 1ps

module ncr_front #(
    parameter int CODE_WIDTH = ncr_pkg::CODE_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_in_byte,
    input  logic          i_end_of_string,
    output logic          o_wr,
    output ncr_pkg::t_rec o_rec
);
    import ncr_pkg::*;

    typedef enum logic [1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_PREAMBLE = 2'd1,
        MODE_BODY     = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        PH_WS     = 3'd0,
        PH_SIGN   = 3'd1,
        PH_ZERO   = 3'd2,
        PH_PREFIX = 3'd3,
        PH_DIGITS = 3'd4,
        PH_DONE   = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_OCT = 2'd1,
        RADIX_HEX = 2'd2
    } t_radix;

    function automatic logic is_space(input logic [7:0] b);
        return b inside {8'h20, [8'h09:8'h0D]};
    endfunction

    // {valid, value} of b as a digit of radix r
    function automatic logic [4:0] digit_val(input logic [7:0] b, input t_radix r);
        logic [4:0] v;
        v = 5'd0;
        if (b inside {[8'h30:8'h39]}) begin
            v = {1'b1, 4'(b - 8'h30)};
        end else if (b inside {[8'h61:8'h66]}) begin
            v = {1'b1, 4'(b - 8'h57)};
        end else if (b inside {[8'h41:8'h46]}) begin
            v = {1'b1, 4'(b - 8'h37)};
        end
        case (r)
            RADIX_HEX: ;
            RADIX_OCT: if (v[3]) v[4] = 1'b0;
            default:   if (v[3:0] > 4'd9) v[4] = 1'b0;
        endcase
        return v;
    endfunction

    t_mode                 r_mode, n_mode;
    logic                  r_hex_req, n_hex_req;
    logic                  r_body_started, n_body_started;
    t_phase                r_phase, n_phase;
    t_radix                r_radix, n_radix;
    logic [CODE_WIDTH-1:0] r_acc, n_acc;
    logic                  r_neg, n_neg;
    logic                  r_digit_seen, n_digit_seen;

    logic                  w_put;
    t_rec                  w_rec;
    logic [4:0]            w_dig;
    logic [CODE_WIDTH-1:0] w_scaled;
    logic [CODE_WIDTH-1:0] w_value;
    logic                  w_start;
    logic                  w_try_digit;

    assign w_dig = digit_val(i_in_byte, r_radix);

    always_comb begin
        case (r_radix)
            RADIX_HEX: w_scaled = r_acc << 4;
            RADIX_OCT: w_scaled = r_acc << 3;
            default:   w_scaled = (r_acc << 3) + (r_acc << 1);
        endcase
    end

    assign w_value = r_neg ? ('0 - r_acc) : r_acc;

    always_comb begin
        n_mode         = r_mode;
        n_hex_req      = r_hex_req;
        n_body_started = r_body_started;
        n_phase        = r_phase;
        n_radix        = r_radix;
        n_acc          = r_acc;
        n_neg          = r_neg;
        n_digit_seen   = r_digit_seen;
        w_put          = 1'b0;
        w_rec          = '0;
        w_start        = 1'b0;
        w_try_digit    = 1'b0;

        case (r_mode)
            MODE_PREAMBLE: begin
                if (i_in_byte != CH_HASH) begin
                    w_put     = 1'b1;
                    w_rec     = '{code: CHAR_W'(i_in_byte), kind: KIND_LITERAL, pair: 1'b1};
                    n_mode    = MODE_NORMAL;
                end else begin
                    n_mode = MODE_BODY;
                end
            end
            MODE_BODY: begin
                if (i_in_byte == CH_X_LC && !r_body_started) begin
                    n_hex_req = 1'b1;
                    n_radix   = RADIX_HEX;
                end else if (i_in_byte == CH_SEMI) begin
                    w_put = 1'b1;
                    if (r_digit_seen) begin
                        w_rec = '{code: CHAR_W'(w_value), kind: KIND_ENTITY, pair: 1'b0};
                    end else begin
                        w_rec = '{code: '0, kind: KIND_ERROR, pair: 1'b0};
                    end
                    n_mode = MODE_NORMAL;
                end else begin
                    n_body_started = 1'b1;
                    case (r_phase)
                        PH_WS: begin
                            if (is_space(i_in_byte)) begin
                                n_phase = r_phase;
                            end else if (i_in_byte == CH_PLUS || i_in_byte == CH_MINUS) begin
                                n_neg   = (i_in_byte == CH_MINUS);
                                n_phase = PH_SIGN;
                            end else begin
                                w_start = 1'b1;
                            end
                        end
                        PH_SIGN: w_start = 1'b1;
                        PH_ZERO: begin
                            if (i_in_byte == CH_X_LC || i_in_byte == CH_X_UC) begin
                                n_radix = RADIX_HEX;
                                n_phase = PH_PREFIX;
                            end else begin
                                w_try_digit = 1'b1;
                            end
                        end
                        PH_PREFIX, PH_DIGITS: w_try_digit = 1'b1;
                        default: n_phase = PH_DONE;
                    endcase

                    if (w_start) begin
                        if (i_in_byte == CH_ZERO) begin
                            n_digit_seen = 1'b1;
                            if (!r_hex_req) n_radix = RADIX_OCT;
                            n_phase = PH_ZERO;
                        end else begin
                            w_try_digit = 1'b1;
                        end
                    end

                    if (w_try_digit) begin
                        if (w_dig[4]) begin
                            n_acc        = w_scaled + CODE_WIDTH'(w_dig[3:0]);
                            n_digit_seen = 1'b1;
                            n_phase      = PH_DIGITS;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                end
            end
            default: begin
                if (i_in_byte == CH_AMP) begin
                    n_mode         = MODE_PREAMBLE;
                    n_hex_req      = 1'b0;
                    n_body_started = 1'b0;
                    n_phase        = PH_WS;
                    n_radix        = RADIX_DEC;
                    n_acc          = '0;
                    n_neg          = 1'b0;
                    n_digit_seen   = 1'b0;
                end else begin
                    n_mode = MODE_NORMAL;
                    w_put  = 1'b1;
                    w_rec  = '{code: CHAR_W'(i_in_byte), kind: KIND_LITERAL, pair: 1'b0};
                end
            end
        endcase

        if (i_end_of_string) begin
            n_mode         = MODE_NORMAL;
            n_hex_req      = 1'b0;
            n_body_started = 1'b0;
            n_phase        = PH_WS;
            n_radix        = RADIX_DEC;
            n_acc          = '0;
            n_neg          = 1'b0;
            n_digit_seen   = 1'b0;
        end
    end

    assign o_wr  = i_accept && w_put;
    assign o_rec = w_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_NORMAL;
            r_hex_req      <= 1'b0;
            r_body_started <= 1'b0;
            r_phase        <= PH_WS;
            r_radix        <= RADIX_DEC;
            r_acc          <= '0;
            r_neg          <= 1'b0;
            r_digit_seen   <= 1'b0;
        end else if (i_accept) begin
            r_mode         <= n_mode;
            r_hex_req      <= n_hex_req;
            r_body_started <= n_body_started;
            r_phase        <= n_phase;
            r_radix        <= n_radix;
            r_acc          <= n_acc;
            r_neg          <= n_neg;
            r_digit_seen   <= n_digit_seen;
        end
    end

endmodule

// ===== rtl/ncr_fifo.sv =====
// short flop queue between front end and back end
// depends on ncr_pkg
`timescale 1ns / 1ps

module ncr_fifo #(
    parameter int DEPTH = ncr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  ncr_pkg::t_rec i_data,
    output logic          o_full,
    input  logic          i_rd,
    output logic          o_empty,
    output ncr_pkg::t_rec o_data
);
    import ncr_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    t_rec             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_wr, w_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        if (w_rd) n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        if (w_wr && !w_rd) n_count = r_count + 1'b1;
        else if (w_rd && !w_wr) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wr_ptr] <= i_data;
    end

endmodule

// ===== rtl/ncr_back.sv =====
// back end: expands queue entries into result beats, holds the output register
// depends on ncr_pkg
`timescale 1ns / 1ps

module ncr_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_empty,
    input  ncr_pkg::t_rec              i_q_data,
    output logic                       o_q_rd,
    input  logic                       i_pop,
    output logic                       o_empty,
    output logic [ncr_pkg::CHAR_W-1:0] o_char_code,
    output ncr_pkg::t_kind             o_kind,
    output logic                       o_last
);
    import ncr_pkg::*;

    logic              r_valid;
    logic              r_pend;
    logic [7:0]        r_pend_code;
    logic [CHAR_W-1:0] r_code;
    t_kind             r_kind;
    logic              r_last;
    logic              w_free;

    assign w_free = !r_valid || i_pop;
    assign o_q_rd = w_free && !r_pend && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (w_free) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else if (!i_q_empty) begin
                r_valid <= 1'b1;
                r_pend  <= i_q_data.pair;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free) begin
            if (r_pend) begin
                r_code <= CHAR_W'(r_pend_code);
                r_kind <= KIND_LITERAL;
                r_last <= 1'b1;
            end else if (!i_q_empty) begin
                r_pend_code <= i_q_data.code[7:0];
                if (i_q_data.pair) begin
                    r_code <= CHAR_W'(CH_AMP);
                    r_kind <= KIND_LITERAL;
                    r_last <= 1'b0;
                end else begin
                    r_code <= i_q_data.code;
                    r_kind <= i_q_data.kind;
                    r_last <= 1'b1;
                end
            end
        end
    end

    assign o_empty     = !r_valid;
    assign o_char_code = r_code;
    assign o_kind      = r_kind;
    assign o_last      = r_last;

endmodule
